// ----- hw/rtl/swm_pkg.sv -----
// Shared types and constants for the star wildcard matcher.
package swm_pkg;

  // Number of pattern positions, one cell each
  localparam int unsigned MaxPattern = 64;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2,
    OP_EOS    = 2'd3
  } op_e;

  // Command broadcast from the control logic to every cell
  typedef struct packed {
    logic       clear;    // empty the pattern, clear both rows
    logic       append;   // write the first free cell, restart matching
    logic       step;     // advance the match row by one string byte
    logic       restore;  // copy the start row into the match row
    logic [7:0] byte_val; // literal for append, string byte for step
    logic       star;     // append: position is a wildcard
  } cmd_t;

endpackage

// ----- hw/rtl/swm_cell.sv -----
// One pattern position: stored literal or star, start bit and match bit.
module swm_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  swm_pkg::cmd_t cmd_i,
  input  logic          valid_left_i,   // left neighbor holds a position
  input  logic          valid_right_i,  // right neighbor holds a position
  input  logic          start_left_i,   // left neighbor start bit
  input  logic          match_left_q_i, // left neighbor match bit, old row
  input  logic          match_left_d_i, // left neighbor match bit, new row
  output logic          valid_o,
  output logic          start_o,
  output logic          match_q_o,
  output logic          match_d_o,
  output logic          last_match_o    // match bit when this is the last position
);
  import swm_pkg::*;

  logic       valid_q, valid_d;
  logic       start_q, start_d;
  logic       match_q, match_d;
  logic [7:0] byte_q;
  logic       star_q;
  logic       sel;
  logic       step_bit;

  // This cell is the next one to be written on append
  assign sel = valid_left_i & ~valid_q;

  // New match bit for one string byte
  always_comb begin
    if (!valid_q) begin
      step_bit = 1'b0;
    end else if (star_q) begin
      step_bit = match_left_d_i | match_q;
    end else begin
      step_bit = (byte_q == cmd_i.byte_val) ? match_left_q_i : 1'b0;
    end
  end

  // Next state of the control bits
  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    match_d = match_q;
    priority if (cmd_i.clear) begin
      valid_d = 1'b0;
      start_d = 1'b0;
      match_d = 1'b0;
    end else if (cmd_i.append) begin
      if (sel) begin
        valid_d = 1'b1;
        start_d = cmd_i.star & start_left_i;
      end
      match_d = start_d;
    end else if (cmd_i.step) begin
      match_d = step_bit;
    end else if (cmd_i.restore) begin
      match_d = start_q;
    end else begin
      match_d = match_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      start_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      match_q <= match_d;
    end
  end

  // Pattern payload, written once per append
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && sel) begin
      byte_q <= cmd_i.byte_val;
      star_q <= cmd_i.star;
    end
  end

  assign valid_o      = valid_q;
  assign start_o      = start_q;
  assign match_q_o    = match_q;
  assign match_d_o    = step_bit;
  assign last_match_o = valid_q & ~valid_right_i & match_q;

endmodule

// ----- hw/rtl/swm_row.sv -----
// Chain of pattern cells plus the empty-prefix head bit.
module swm_row (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  swm_pkg::cmd_t cmd_i,
  output logic          full_o,     // every position is in use
  output logic          matched_o   // match bit at the pattern length
);
  import swm_pkg::*;

  logic                  head_match_q, head_match_d;
  logic [MaxPattern:0]   valid_w;
  logic [MaxPattern:0]   start_w;
  logic [MaxPattern:0]   match_q_w;
  logic [MaxPattern:0]   match_d_w;
  logic [MaxPattern:0]   valid_right_w;
  logic [MaxPattern-1:0] last_w;

  // Head bit: empty prefix matches only before any string byte
  always_comb begin
    priority if (cmd_i.step) begin
      head_match_d = 1'b0;
    end else if (cmd_i.clear || cmd_i.append || cmd_i.restore) begin
      head_match_d = 1'b1;
    end else begin
      head_match_d = head_match_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_match_q <= 1'b1;
    end else begin
      head_match_q <= head_match_d;
    end
  end

  assign valid_w[0]   = 1'b1;
  assign start_w[0]   = 1'b1;
  assign match_q_w[0] = head_match_q;
  assign match_d_w[0] = 1'b0;

  // Right-neighbor valid for each cell; nothing past the end
  assign valid_right_w[MaxPattern] = 1'b0;

  for (genvar j = 1; j <= MaxPattern; j++) begin : g_cell
    assign valid_right_w[j-1] = valid_w[j];

    swm_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd_i),
      .valid_left_i   (valid_w[j-1]),
      .valid_right_i  (valid_right_w[j]),
      .start_left_i   (start_w[j-1]),
      .match_left_q_i (match_q_w[j-1]),
      .match_left_d_i (match_d_w[j-1]),
      .valid_o        (valid_w[j]),
      .start_o        (start_w[j]),
      .match_q_o      (match_q_w[j]),
      .match_d_o      (match_d_w[j]),
      .last_match_o   (last_w[j-1])
    );
  end

  assign full_o    = valid_w[MaxPattern];
  assign matched_o = (|last_w) | (head_match_q & ~valid_right_w[0]);

endmodule

// ----- hw/rtl/star_wildcard_matcher_core.sv -----
// Top level: operation decode, overflow flag and result register.
// Throughput: one item per cycle; the input stalls only while a result waits.
// A result is registered and appears in the cycle after its end-of-string transfer.
// Cycle time is set by the star chain rippling through consecutive cells.
// Reset (rst_ni low, async): empty pattern, rows at bit zero only,
// overflow flag clear, no result pending. Pattern bytes are not reset.
module star_wildcard_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_op_i,
  input  logic [7:0] in_byte_value_i,
  input  logic       in_is_star_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_matched_o,
  output logic       out_pattern_overflow_o
);
  import swm_pkg::*;

  logic in_xfer;
  logic full;
  logic row_matched;
  logic overflow_q, overflow_d;
  logic out_valid_q, out_valid_d;
  logic out_matched_q;
  logic out_overflow_q;
  cmd_t cmd;

  // Hold the input while a result waits downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Operation decode into the cell command
  always_comb begin
    cmd          = '0;
    cmd.byte_val = in_byte_value_i;
    cmd.star     = in_is_star_i;
    overflow_d   = overflow_q;
    if (in_xfer) begin
      unique case (op_e'(in_op_i))
        OP_CLEAR: begin
          cmd.clear  = 1'b1;
          overflow_d = 1'b0;
        end
        OP_APPEND: begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
        end
        OP_BYTE:  cmd.step    = 1'b1;
        OP_EOS:   cmd.restore = 1'b1;
        default:  cmd.step    = 1'b0;
      endcase
    end
  end

  swm_row u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .full_o    (full),
    .matched_o (row_matched)
  );

  // Result register valid
  always_comb begin
    if (cmd.restore) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd.restore) begin
      out_matched_q  <= row_matched;
      out_overflow_q <= overflow_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_matched_o          = out_matched_q;
  assign out_pattern_overflow_o = out_overflow_q;

endmodule

// ----- hw/rtl/swm_checker.sv -----
// Port-level checks for the matcher core, bound to the top level.
module swm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] in_op_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       out_matched_o,
  input logic       out_pattern_overflow_o
);
  import swm_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // A new result follows an end-of-string transfer
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_xfer && in_op_i == OP_EOS))
    else $error("result without end of string");

  // Empty pattern, empty string: match and no overflow
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op_i == OP_CLEAR) ##1 (in_xfer && in_op_i == OP_EOS)
    |=> out_valid_o && out_matched_o && !out_pattern_overflow_o)
    else $error("empty pattern did not match empty string");

endmodule

bind star_wildcard_matcher_core swm_checker u_swm_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_valid_i),
  .in_stall_o             (in_stall_o),
  .in_op_i                (in_op_i),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .out_matched_o          (out_matched_o),
  .out_pattern_overflow_o (out_pattern_overflow_o)
);

// ----- tb/sv/star_wildcard_matcher_core_test.sv -----
// Testbench for the star wildcard matcher core: directed and random stimulus, scoreboard check.
`timescale 1ns / 1ps

module star_wildcard_matcher_core_test;
  import swm_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned ItemGoal  = 1550;

  // One end-of-string verdict
  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // Scoreboard: tracks the pattern and match rows, holds verdicts still owed
  class pattern_match_board;
    logic [7:0]          pat_byte [MaxPattern];
    logic                pat_star [MaxPattern];
    int unsigned         pat_len;
    logic [MaxPattern:0] live_row;
    logic [MaxPattern:0] base_row;
    logic                sticky_ovf;
    verdict_t            owed_verdicts [$];
    int unsigned         errors;

    function new();
      foreach (pat_byte[i]) begin
        pat_byte[i] = '0;
        pat_star[i] = 1'b0;
      end
      pat_len    = 0;
      base_row   = '0;
      base_row[0] = 1'b1;
      live_row   = base_row;
      sticky_ovf = 1'b0;
      errors     = 0;
    endfunction

    // Advance the match row by one string byte
    function void step_row(logic [7:0] b);
      logic [MaxPattern:0] nxt;
      nxt = '0;
      for (int unsigned j = 1; j <= pat_len; j++) begin
        if (pat_star[j-1]) begin
          nxt[j] = nxt[j-1] | live_row[j];
        end else if (pat_byte[j-1] == b) begin
          nxt[j] = live_row[j-1];
        end else begin
          nxt[j] = 1'b0;
        end
      end
      live_row = nxt;
    endfunction

    // Update the model for one accepted input transfer
    function void note_transfer(op_e op, logic [7:0] b, logic s);
      verdict_t v;
      case (op)
        OP_CLEAR: begin
          pat_len     = 0;
          sticky_ovf  = 1'b0;
          base_row    = '0;
          base_row[0] = 1'b1;
          live_row    = base_row;
        end
        OP_APPEND: begin
          if (pat_len >= MaxPattern) begin
            sticky_ovf = 1'b1;
          end else begin
            pat_byte[pat_len]   = b;
            pat_star[pat_len]   = s;
            base_row[pat_len+1] = s ? base_row[pat_len] : 1'b0;
            pat_len++;
            live_row = base_row;
          end
        end
        OP_BYTE: step_row(b);
        default: begin
          v.matched  = live_row[pat_len];
          v.overflow = sticky_ovf;
          owed_verdicts.push_back(v);
          live_row = base_row;
        end
      endcase
    endfunction

    // Compare one accepted result against the oldest owed verdict
    function void check_verdict(logic m, logic o);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: matched=%0b overflow=%0b", $time, m, o);
        return;
      end
      want = owed_verdicts.pop_front();
      if (m !== want.matched) begin
        errors++;
        $display("%0t: matched mismatch: expected %0b actual %0b", $time, want.matched, m);
      end
      if (o !== want.overflow) begin
        errors++;
        $display("%0t: pattern_overflow mismatch: expected %0b actual %0b",
                 $time, want.overflow, o);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] in_op_i;
  logic [7:0] in_byte_value_i;
  logic       in_is_star_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       out_matched_o;
  logic       out_pattern_overflow_o;

  pattern_match_board board;
  int unsigned        items_sent;
  int unsigned        idle_cycles;
  bit                 calm;
  bit                 long_hold_req;
  bit                 narrow;
  logic [7:0]         alpha_base;
  logic [7:0]         tb_bytes [$];
  bit                 tb_stars [$];

  star_wildcard_matcher_core dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_op_i                (in_op_i),
    .in_byte_value_i        (in_byte_value_i),
    .in_is_star_i           (in_is_star_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_matched_o          (out_matched_o),
    .out_pattern_overflow_o (out_pattern_overflow_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte source: a narrow alphabet gives frequent matches
  function automatic logic [7:0] draw_byte();
    if (narrow) return alpha_base + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  // Offer one item after a random gap (none when calm) and wait for its transfer
  task automatic send_item(op_e op, logic [7:0] b, logic s);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_op_i         <= op;
    in_byte_value_i <= b;
    in_is_star_i    <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_transfer(op, b, s);
    items_sent++;
  endtask

  // Clear, then append len positions; keep a local copy for string building
  task automatic load_pattern(int unsigned len);
    logic [7:0] b;
    bit         s;
    send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
    tb_bytes.delete();
    tb_stars.delete();
    repeat (len) begin
      s = ($urandom_range(0, 2) == 0);
      b = draw_byte();
      send_item(OP_APPEND, b, s);
      if (tb_bytes.size() < MaxPattern) begin
        tb_bytes.push_back(b);
        tb_stars.push_back(s);
      end
    end
  endtask

  // Stream one string, built to match or drawn at random, then end it
  task automatic send_string(bit want_match);
    int unsigned n;
    if (want_match) begin
      foreach (tb_bytes[i]) begin
        if (tb_stars[i]) begin
          repeat ($urandom_range(0, 3)) send_item(OP_BYTE, draw_byte(), 1'($urandom));
        end else begin
          send_item(OP_BYTE, tb_bytes[i], 1'($urandom));
        end
      end
    end else begin
      n = $urandom_range(0, tb_bytes.size() + 2);
      repeat (n) send_item(OP_BYTE, draw_byte(), 1'($urandom));
    end
    send_item(OP_EOS, 8'($urandom), 1'($urandom));
  endtask

  // Receiver: random stall per result, one long hold on request
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        hold = LongHold;
        long_hold_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
        while (!out_valid_o) @(posedge clk_i);
        repeat (hold - 1) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_verdict(out_matched_o, out_pattern_overflow_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("star_wildcard_matcher_core test failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned phase;
    int unsigned r;
    int unsigned len;
    board           = new();
    items_sent      = 0;
    idle_cycles     = 0;
    calm            = 1'b0;
    long_hold_req   = 1'b0;
    narrow          = 1'b1;
    alpha_base      = 8'h61;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_op_i         = OP_CLEAR;
    in_byte_value_i = '0;
    in_is_star_i    = 1'b0;
    out_stall_i     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pattern, empty string and single byte
    send_item(OP_EOS, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b1);
    send_item(OP_EOS, 8'hFF, 1'b1);
    // Lone star matches the empty string
    send_item(OP_APPEND, 8'hFF, 1'b1);
    send_item(OP_EOS, 8'h00, 1'b0);
    // Star then literal at the byte extremes
    send_item(OP_APPEND, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_EOS, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h7F, 1'b1);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_EOS, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_EOS, 8'h00, 1'b0);
    // Append in the middle of a string abandons it
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_APPEND, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_EOS, 8'h00, 1'b0);
    // Clear mid-string, then empty string on empty pattern
    send_item(OP_BYTE, 8'h80, 1'b0);
    send_item(OP_CLEAR, 8'hFF, 1'b1);
    send_item(OP_EOS, 8'hFF, 1'b1);

    // Random phases
    phase = 0;
    while (items_sent < ItemGoal) begin
      r          = $urandom_range(0, 9);
      calm       = ($urandom_range(0, 3) == 0);
      narrow     = ($urandom_range(0, 3) != 0);
      alpha_base = 8'($urandom);
      if (phase == 0) begin
        len = 66;
      end else if (phase == 1) begin
        len = MaxPattern;
      end else if ($urandom_range(0, 15) == 0) begin
        len = $urandom_range(60, 70);
      end else begin
        len = $urandom_range(0, 8);
      end
      if (phase == 4) begin
        // Long receiver hold while the sender keeps offering
        load_pattern($urandom_range(0, 3));
        calm = 1'b1;
        long_hold_req = 1'b1;
        repeat (8) send_item(OP_EOS, 8'($urandom), 1'($urandom));
      end else if (phase < 2 || r < 8) begin
        load_pattern(len);
        repeat ($urandom_range(1, 5)) begin
          send_string($urandom_range(0, 1));
          if ($urandom_range(0, 5) == 0) send_item(OP_EOS, 8'($urandom), 1'($urandom));
        end
      end else if (r == 8) begin
        // Noise: any op, any fields
        repeat (10) send_item(op_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end else begin
        // Broken sequence: string interrupted by an append or a clear
        load_pattern(len);
        repeat ($urandom_range(0, 4)) send_item(OP_BYTE, draw_byte(), 1'($urandom));
        send_item($urandom_range(0, 1) ? OP_APPEND : OP_CLEAR, draw_byte(), 1'($urandom));
        send_string($urandom_range(0, 1));
      end
      phase++;
    end

    // Drain remaining results
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (board.owed_verdicts.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.owed_verdicts.size() == 0) begin
      $display("star_wildcard_matcher_core test passed");
    end else begin
      $display("star_wildcard_matcher_core test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_row.sv
hw/rtl/star_wildcard_matcher_core.sv
hw/rtl/swm_checker.sv
tb/sv/star_wildcard_matcher_core_test.sv
